FILE: src/twls_pkg.sv
// Shared types and constants for the tape wave length scanner.
// No dependencies; imported by tape_wave_length_scanner_unit and tb_top.
package twls_pkg;

  // Sample and count widths
  localparam int SAMPLE_W    = 8;
  localparam int COUNT_WIDTH = 24;
  localparam int LEN_W       = 24;
  localparam int LEVEL_W     = 7;
  localparam int LIMIT_W     = 24;
  localparam int BLOCKS_W    = 8;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [LEN_W-1:0]       LEN_MAX   = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Register reset values
  localparam logic [LEVEL_W-1:0]  MIN_LEVEL_RST   = LEVEL_W'(10);
  localparam logic                HALF_WAVES_RST  = 1'b0;
  localparam logic [LIMIT_W-1:0]  LONG_LIMIT_RST  = LIMIT_W'(2000);
  localparam logic [BLOCKS_W-1:0] BLOCK_LIMIT_RST = '0;

  // Register index, taken from paddr word bits
  typedef enum logic [1:0] {
    REG_MIN_LEVEL   = 2'd0,
    REG_HALF_WAVES  = 2'd1,
    REG_LONG_LIMIT  = 2'd2,
    REG_BLOCK_LIMIT = 2'd3
  } reg_idx_t;

  // Result kinds
  localparam logic KIND_GAP  = 1'b0;
  localparam logic KIND_WAVE = 1'b1;

  // Scan phase
  typedef enum logic [2:0] {
    PH_LEAD_LEVEL = 3'd0,
    PH_LEAD_POS   = 3'd1,
    PH_START      = 3'd2,
    PH_SKIP       = 3'd3,
    PH_RUN        = 3'd4,
    PH_STOPPED    = 3'd5
  } phase_t;

endpackage

FILE: src/tape_wave_length_scanner_unit.sv
// Tape wave length scanner: zero-crossing run measurement over 8-bit samples.
// Depends on twls_pkg for widths, register indexes and the phase type.
//
//   channel   signals                                   payload
//   in        in_valid / in_ready                       sample, last_sample
//   out       out_valid / out_ready                     kind, length, block_end, finished
//   config    psel penable pwrite paddr pwdata prdata   four registers, word addressed
//
// Every sample is resolved in the cycle it is accepted: one compare on the swing,
// one saturating counter update, one result register. Throughput is one sample
// per cycle; a result is valid the cycle after the accepting edge. Every sample
// waits while the result register is full and not taken. Reset is synchronous
// and restores the config, scan and out_valid registers and the lead-in phase.
module tape_wave_length_scanner_unit (
  input  logic                              clk,
  input  logic                              rst,
  // sample input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [twls_pkg::SAMPLE_W-1:0] sample,
  input  logic                              last_sample,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              kind,
  output logic [twls_pkg::LEN_W-1:0]        length,
  output logic                              block_end,
  output logic                              finished,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [twls_pkg::ADDR_W-1:0]       paddr,
  input  logic [twls_pkg::DATA_W-1:0]       pwdata,
  output logic [twls_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import twls_pkg::*;

  // Configuration registers
  logic [LEVEL_W-1:0]  min_level;
  logic                half_waves;
  logic [LIMIT_W-1:0]  long_wave_limit;
  logic [BLOCKS_W-1:0] block_limit;

  // Scan state
  phase_t                   phase, phase_next;
  logic signed [SAMPLE_W-1:0] lowest_sample, lowest_sample_next;
  logic                     run_is_negative, run_is_negative_next;
  logic                     run_valid, run_valid_next;
  logic [COUNT_WIDTH-1:0]   sample_count, sample_count_next;
  logic [BLOCKS_W-1:0]      blocks_left, blocks_left_next;

  logic     cfg_write;
  reg_idx_t cfg_idx;
  logic     in_take;

  // Decode of the current sample
  logic                       lead_hit;
  phase_t                     ph_eff;
  logic                       s_pos, s_neg, s_zero, is_match;
  logic [LEVEL_W-1:0]         thr;
  logic signed [SAMPLE_W+1:0] swing;
  logic                       level_hit;
  logic                       end_run, gap_emit, wave_emit, long_wave, fin, fresh;
  logic [COUNT_WIDTH-1:0]     count_inc, base_count, base_inc;
  logic signed [SAMPLE_W-1:0] base_low;
  logic                       base_valid, base_neg;
  logic [LEN_W-1:0]           len_sat;

  // Start-sample results
  phase_t                     st_phase;
  logic signed [SAMPLE_W-1:0] st_low;
  logic                       st_neg, st_valid;

  // Result to load
  logic              emit;
  logic              emit_kind, emit_be, emit_fin;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign in_ready  = !out_valid || out_ready;
  assign in_take   = in_valid && in_ready;

  // Register read back
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_MIN_LEVEL:   prdata = DATA_W'(min_level);
      REG_HALF_WAVES:  prdata = DATA_W'(half_waves);
      REG_LONG_LIMIT:  prdata = DATA_W'(long_wave_limit);
      REG_BLOCK_LIMIT: prdata = DATA_W'(block_limit);
      default:         prdata = '0;
    endcase
  end

  // Sample classification and level check
  assign lead_hit  = (phase == PH_LEAD_LEVEL) &&
                     !(sample < $signed({1'b0, min_level}));
  assign ph_eff    = lead_hit ? PH_LEAD_POS : phase;
  assign s_neg     = sample[SAMPLE_W-1];
  assign s_zero    = (sample == '0);
  assign s_pos     = !s_neg && !s_zero;
  assign is_match  = run_is_negative ? s_neg : s_pos;
  assign thr       = half_waves ? (min_level >> 1) : min_level;

  always_comb begin
    if (run_is_negative) begin
      swing = -(SAMPLE_W+2)'(sample);
    end else if (half_waves) begin
      swing = (SAMPLE_W+2)'(sample);
    end else begin
      swing = (SAMPLE_W+2)'(sample) - (SAMPLE_W+2)'(lowest_sample);
    end
  end
  assign level_hit = swing >= $signed({3'b000, thr});

  // Run ends, results and budget
  assign end_run   = ((ph_eff == PH_SKIP) && !s_zero && !is_match) ||
                     ((ph_eff == PH_RUN) && !is_match);
  assign gap_emit  = (ph_eff == PH_LEAD_POS) && !s_pos;
  assign wave_emit = end_run && run_valid;
  assign long_wave = 32'(sample_count) > 32'(long_wave_limit);
  assign fin       = wave_emit && long_wave && (blocks_left == BLOCKS_W'(1));
  assign len_sat   = (32'(sample_count) > 32'(LEN_MAX)) ? LEN_MAX
                                                        : LEN_W'(32'(sample_count));

  // Saturating counts, on the current wave or a fresh one
  assign count_inc  = (sample_count == COUNT_MAX) ? sample_count
                                                  : sample_count + COUNT_WIDTH'(1);
  assign fresh      = gap_emit || wave_emit;
  assign base_count = fresh ? '0 : sample_count;
  assign base_low   = fresh ? '0 : lowest_sample;
  assign base_valid = fresh ? 1'b0 : run_valid;
  assign base_neg   = fresh ? 1'b0 : run_is_negative;
  assign base_inc   = (base_count == COUNT_MAX) ? base_count
                                                : base_count + COUNT_WIDTH'(1);

  // Take a start sample
  always_comb begin
    st_phase = PH_SKIP;
    st_low   = base_low;
    st_neg   = 1'b0;
    st_valid = 1'b0;
    if (half_waves) begin
      if (s_zero) begin
        st_phase = PH_START;
        st_neg   = base_neg;
        st_valid = base_valid;
      end else begin
        st_low = '0;
        st_neg = s_neg;
      end
    end else if (sample < base_low) begin
      st_low = sample;
    end
  end

  // Next state
  always_comb begin
    phase_next           = phase;
    lowest_sample_next   = lowest_sample;
    run_is_negative_next = run_is_negative;
    run_valid_next       = run_valid;
    sample_count_next    = sample_count;
    blocks_left_next     = blocks_left;
    unique case (ph_eff)
      PH_LEAD_LEVEL: begin
        sample_count_next = count_inc;
      end
      PH_LEAD_POS, PH_START, PH_SKIP, PH_RUN: begin
        if ((ph_eff == PH_LEAD_POS) && s_pos) begin
          phase_next        = PH_LEAD_POS;
          sample_count_next = count_inc;
        end else if (((ph_eff == PH_SKIP) && !s_zero && is_match) ||
                     ((ph_eff == PH_RUN) && is_match)) begin
          phase_next        = PH_RUN;
          run_valid_next    = run_valid || level_hit;
          sample_count_next = count_inc;
        end else if ((ph_eff == PH_SKIP) && s_zero) begin
          sample_count_next = count_inc;
        end else if (fin) begin
          phase_next           = PH_STOPPED;
          lowest_sample_next   = '0;
          run_is_negative_next = 1'b0;
          run_valid_next       = 1'b0;
          sample_count_next    = '0;
        end else begin
          phase_next           = st_phase;
          lowest_sample_next   = st_low;
          run_is_negative_next = st_neg;
          run_valid_next       = st_valid;
          sample_count_next    = base_inc;
        end
      end
      PH_STOPPED: begin
        phase_next = PH_STOPPED;
      end
      default: begin
        phase_next = PH_LEAD_LEVEL;
      end
    endcase
    // Spend one block of the budget
    if (wave_emit && long_wave && (blocks_left != '0)) begin
      blocks_left_next = blocks_left - BLOCKS_W'(1);
    end
    // Restart for a new recording after the last sample
    if (last_sample) begin
      phase_next           = PH_LEAD_LEVEL;
      lowest_sample_next   = '0;
      run_is_negative_next = 1'b0;
      run_valid_next       = 1'b0;
      sample_count_next    = '0;
      blocks_left_next     = block_limit;
    end
  end

  // Result fields
  always_comb begin
    emit      = gap_emit || wave_emit;
    emit_kind = gap_emit ? KIND_GAP : KIND_WAVE;
    emit_be   = wave_emit && long_wave;
    emit_fin  = fin;
  end

  // Configuration and scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_level       <= MIN_LEVEL_RST;
      half_waves      <= HALF_WAVES_RST;
      long_wave_limit <= LONG_LIMIT_RST;
      block_limit     <= BLOCK_LIMIT_RST;
      phase           <= PH_LEAD_LEVEL;
      lowest_sample   <= '0;
      run_is_negative <= 1'b0;
      run_valid       <= 1'b0;
      sample_count    <= '0;
      blocks_left     <= BLOCK_LIMIT_RST;
    end else begin
      if (in_take) begin
        phase           <= phase_next;
        lowest_sample   <= lowest_sample_next;
        run_is_negative <= run_is_negative_next;
        run_valid       <= run_valid_next;
        sample_count    <= sample_count_next;
      end
      // Reload the budget on a block limit write, else advance it with the item
      if (cfg_write && (cfg_idx == REG_BLOCK_LIMIT)) begin
        blocks_left <= pwdata[BLOCKS_W-1:0];
      end else if (in_take) begin
        blocks_left <= blocks_left_next;
      end
      if (cfg_write) begin
        unique case (cfg_idx)
          REG_MIN_LEVEL:   min_level       <= pwdata[LEVEL_W-1:0];
          REG_HALF_WAVES:  half_waves      <= pwdata[0];
          REG_LONG_LIMIT:  long_wave_limit <= pwdata[LIMIT_W-1:0];
          REG_BLOCK_LIMIT: block_limit     <= pwdata[BLOCKS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result register: load on an emitting item, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      kind      <= emit_kind;
      length    <= len_sat;
      block_end <= emit_be;
      finished  <= emit_fin;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for tape_wave_length_scanner_unit: directed and random
// sample streams checked against a scan predictor kept in step with every item.
// Depends on twls_pkg and the block under test; no files, no arguments.
module tb_top;
  import twls_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int TAIL_ITEMS   = 200;

  typedef struct packed {
    logic             kind;
    logic [LEN_W-1:0] length;
    logic             block_end;
    logic             finished;
  } wave_res_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic last_sample;
  logic out_valid, out_ready;
  logic kind;
  logic [LEN_W-1:0] length;
  logic block_end, finished;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  // Predictor copy of the registers
  logic [LEVEL_W-1:0]  cfg_level;
  logic                cfg_half;
  logic [LIMIT_W-1:0]  cfg_long;
  logic [BLOCKS_W-1:0] cfg_blocks;

  // Predictor copy of the scan state
  phase_t                 ph;
  int                     low_start;
  bit                     neg_run;
  bit                     run_ok;
  logic [COUNT_WIDTH-1:0] n_samples;
  logic [BLOCKS_W-1:0]    budget;

  wave_res_t   length_q[$];
  int          fail_count = 0;
  int          items_sent = 0;
  int unsigned cycle_count = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  bit          hold_req = 1'b0;

  tape_wave_length_scanner_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .length      (length),
    .block_end   (block_end),
    .finished    (finished),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void bump_count();
    if (n_samples != COUNT_MAX) n_samples++;
  endfunction

  function automatic void clear_wave();
    n_samples = '0;
    low_start = 0;
    run_ok    = 1'b0;
    neg_run   = 1'b0;
  endfunction

  function automatic void restart_recording();
    ph = PH_LEAD_LEVEL;
    clear_wave();
    budget = cfg_blocks;
  endfunction

  // Consume a start sample: sign in half-wave mode, running minimum otherwise
  function automatic void take_start(int s);
    bump_count();
    if (cfg_half) begin
      if (s == 0) begin
        ph = PH_START;
        return;
      end
      neg_run   = (s < 0);
      low_start = 0;
    end else begin
      if (s < low_start) low_start = s;
      neg_run = 1'b0;
    end
    run_ok = 1'b0;
    ph     = PH_SKIP;
  endfunction

  function automatic bit polarity_match(int s);
    return neg_run ? (s < 0) : (s > 0);
  endfunction

  function automatic void level_check(int s);
    int thr;
    int swing;
    thr   = cfg_half ? int'(cfg_level >> 1) : int'(cfg_level);
    swing = neg_run ? -s : s - (cfg_half ? 0 : low_start);
    if (swing >= thr) run_ok = 1'b1;
  endfunction

  function automatic void push_length(logic k, logic be, logic fin);
    wave_res_t r;
    r.kind      = k;
    r.length    = (32'(n_samples) > 32'(LEN_MAX)) ? LEN_MAX : LEN_W'(32'(n_samples));
    r.block_end = be;
    r.finished  = fin;
    length_q.push_back(r);
  endfunction

  // Close a run: an invalid run restarts the attempt, a valid one ends the wave
  function automatic void close_run(int s);
    logic be;
    logic fin;
    if (!run_ok) begin
      take_start(s);
      return;
    end
    be  = (32'(n_samples) > 32'(cfg_long));
    fin = 1'b0;
    if (be && budget != '0) begin
      budget--;
      if (budget == '0) fin = 1'b1;
    end
    push_length(KIND_WAVE, be, fin);
    clear_wave();
    if (fin) ph = PH_STOPPED;
    else take_start(s);
  endfunction

  // Advance the scan by one accepted item
  function automatic void scan_sample(logic signed [SAMPLE_W-1:0] smp, logic last);
    int s = smp;
    if (ph == PH_LEAD_LEVEL) begin
      if (s < int'(cfg_level)) bump_count();
      else ph = PH_LEAD_POS;
    end
    if (ph == PH_LEAD_POS) begin
      if (s > 0) begin
        bump_count();
      end else begin
        push_length(KIND_GAP, 1'b0, 1'b0);
        clear_wave();
        take_start(s);
      end
    end else if (ph == PH_START) begin
      take_start(s);
    end else if (ph == PH_SKIP) begin
      if (s == 0) begin
        bump_count();
      end else if (polarity_match(s)) begin
        level_check(s);
        bump_count();
        ph = PH_RUN;
      end else begin
        close_run(s);
      end
    end else if (ph == PH_RUN) begin
      if (polarity_match(s)) begin
        level_check(s);
        bump_count();
      end else begin
        close_run(s);
      end
    end
    if (last) restart_recording();
  endfunction

  function automatic void apply_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    case (idx)
      REG_MIN_LEVEL:  cfg_level = value[LEVEL_W-1:0];
      REG_HALF_WAVES: cfg_half  = value[0];
      REG_LONG_LIMIT: cfg_long  = value[LIMIT_W-1:0];
      REG_BLOCK_LIMIT: begin
        cfg_blocks = value[BLOCKS_W-1:0];
        budget     = cfg_blocks;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] reg_value(reg_idx_t idx);
    case (idx)
      REG_MIN_LEVEL:  return DATA_W'(cfg_level);
      REG_HALF_WAVES: return DATA_W'(cfg_half);
      REG_LONG_LIMIT: return DATA_W'(cfg_long);
      default:        return DATA_W'(cfg_blocks);
    endcase
  endfunction

  // ---------------------------------------------------------------- result side

  // Drive out_ready: random stall bursts, or one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (recv_idle && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 17);
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expected length
  always @(posedge clk) begin : length_check
    wave_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (length_q.size() == 0) begin
        $error("unexpected result: kind=%0d length=%0d", kind, length);
        fail_count++;
      end else begin
        want = length_q.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          fail_count++;
        end
        if (length !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, length);
          fail_count++;
        end
        if (block_end !== want.block_end) begin
          $error("block_end: expected %0d, got %0d", want.block_end, block_end);
          fail_count++;
        end
        if (finished !== want.finished) begin
          $error("finished: expected %0d, got %0d", want.finished, finished);
          fail_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  // Offer one item, hold it until accepted, then advance the predictor
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    int gap;
    if (send_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample      <= s;
    last_sample <= last;
    do @(posedge clk); while (!in_ready);
    scan_sample(s, last);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected length has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (length_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // One register access: setup cycle, access cycle, then idle with psel low
  task automatic apb_access(input reg_idx_t idx, input logic wr,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) apply_reg(idx, wdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input reg_idx_t idx);
    logic [DATA_W-1:0] rd;
    apb_access(idx, 1'b0, '0, rd);
    if (rd !== reg_value(idx)) begin
      $error("%s readback: expected %0d, got %0d", idx.name(), reg_value(idx), rd);
      fail_count++;
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd;
    apb_access(idx, 1'b1, value, rd);
    check_reg(idx);
  endtask

  // Write all four registers; call only with nothing in flight
  task automatic set_scan(input int lvl, input int half, input int lim, input int blk);
    write_reg(REG_MIN_LEVEL, DATA_W'(lvl));
    write_reg(REG_HALF_WAVES, DATA_W'(half));
    write_reg(REG_LONG_LIMIT, DATA_W'(lim));
    write_reg(REG_BLOCK_LIMIT, DATA_W'(blk));
  endtask

  task automatic send_list(input int vals[$], input bit last_at_end);
    foreach (vals[i])
      send_sample(SAMPLE_W'(vals[i]), last_at_end && (i == vals.size() - 1));
  endtask

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  // Random samples over the full range, with an occasional end of recording
  task automatic send_noise(input int n);
    repeat (n) send_sample(SAMPLE_W'(rand_between(-128, 127)), $urandom_range(0, 39) == 0);
  endtask

  // One recording: lead-in, then alternating runs, some too faint to count
  task automatic send_recording(input int n_runs);
    int  lvl;
    int  n;
    int  val;
    int  hi;
    bit  faint;
    bit  flip_end;
    lvl      = int'(cfg_level);
    hi       = (lvl / 3 > 1) ? lvl / 3 : 1;
    flip_end = $urandom_range(0, 1);
    repeat ($urandom_range(0, 5)) send_sample(SAMPLE_W'(rand_between(-20, lvl - 1)), 1'b0);
    send_sample(SAMPLE_W'(rand_between(lvl, 127)), 1'b0);
    repeat ($urandom_range(0, 3)) send_sample(SAMPLE_W'(rand_between(1, 127)), 1'b0);
    for (int r = 0; r < n_runs; r++) begin
      n     = $urandom_range(1, 6);
      faint = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) val = 0;
        else if (faint) val = rand_between(1, hi);
        else val = rand_between((lvl / 2 > 1) ? lvl / 2 : 1, 127);
        if (r % 2 == 0) val = -val;
        send_sample(SAMPLE_W'(val), !flip_end && r == n_runs - 1 && i == n - 1);
      end
    end
    // End on a sign change so the last item itself closes the run
    if (flip_end)
      send_sample(SAMPLE_W'((n_runs % 2 == 0) ? -rand_between(1, 128) : rand_between(1, 127)),
                  1'b1);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    check_reg(REG_MIN_LEVEL);
    check_reg(REG_HALF_WAVES);
    check_reg(REG_LONG_LIMIT);
    check_reg(REG_BLOCK_LIMIT);
  endtask

  // Lead-in gap, zero skipping, invalid run, running minimum, cut-off run
  task automatic test_full_wave_directed();
    int seq[$];
    seq = '{3, -128, 127, 5, 0, 0, 2, -5, 6, -1, 127, -128, 127, 1};
    send_list(seq, 1'b1);
    wait_for_results();
  endtask

  // Half threshold, zero start samples, both polarities, extremes
  task automatic test_half_wave_directed();
    int seq[$];
    set_scan(127, 1, 2000, 0);
    seq = '{70, 127, -1, -63, 0, 0, 64, 1, -128, -128, 127, 5};
    send_list(seq, 1'b1);
    wait_for_results();
  endtask

  // Budget runs out, later items are ignored, the next recording reloads it
  task automatic test_block_budget();
    int seq[$];
    set_scan(10, 0, 0, 2);
    seq = '{50, -50, 50, -50, 50, -50, 50, -50, 30, 0};
    send_list(seq, 1'b1);
    seq = '{50, -50, 50, -50, 50, -50};
    send_list(seq, 1'b1);
    wait_for_results();
  endtask

  // Long receiver hold-off while items keep coming, then a full pause
  task automatic test_backpressure();
    set_scan(20, 1, 2000, 0);
    send_idle = 1'b0;
    hold_req  = 1'b1;
    send_recording(40);
    wait_for_results();
    send_idle = 1'b1;
  endtask

  task automatic test_random_scan(input int n_items);
    int lvl, half, lim, blk, target;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin lvl = 10;  half = 0; lim = 2000;    blk = 0;   end
        1: begin lvl = 0;   half = 1; lim = 0;       blk = 0;   end
        2: begin lvl = 127; half = 0; lim = LEN_MAX; blk = 255; end
        3: begin lvl = 127; half = 1; lim = 5;       blk = 3;   end
        4: begin
          lvl  = $urandom_range(0, 127);
          half = $urandom_range(0, 1);
          lim  = $urandom_range(0, 12);
          blk  = $urandom_range(1, 4);
        end
        default: begin
          lvl  = $urandom_range(0, 127);
          half = $urandom_range(0, 1);
          lim  = $urandom_range(0, 1) ? $urandom_range(0, 16) : $urandom_range(0, LEN_MAX);
          blk  = $urandom_range(0, 255);
        end
      endcase
      wait_for_results();
      set_scan(lvl, half, lim, blk);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      target    = items_sent + n_items / 8;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0) send_noise($urandom_range(5, 20));
        else send_recording($urandom_range(1, 12));
      end
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_quiet_tail(input int n_items);
    int target;
    wait_for_results();
    set_scan(12, 0, 6, 0);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    target    = items_sent + n_items;
    while (items_sent < target) send_recording($urandom_range(2, 10));
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    sample      = '0;
    last_sample = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cfg_level   = MIN_LEVEL_RST;
    cfg_half    = HALF_WAVES_RST;
    cfg_long    = LONG_LIMIT_RST;
    cfg_blocks  = BLOCK_LIMIT_RST;
    restart_recording();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values();
    test_full_wave_directed();
    test_half_wave_directed();
    test_block_budget();
    test_backpressure();
    test_random_scan(RANDOM_ITEMS);
    test_quiet_tail(TAIL_ITEMS);

    wait_for_results();
    repeat (10) @(negedge clk);
    if (length_q.size() != 0) begin
      $error("%0d expected lengths never arrived", length_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
